// ----- hdl/tbb_pkg.sv -----
// Shared constants and types for the EDT token bucket rate limiter.
`default_nettype none
package tbb_pkg;
    localparam int NUM_CLASSES = 16;
    localparam int CID_W       = 4;
    localparam int NOW_W       = 63;
    localparam int EDT_W       = 64;
    localparam int CNT_W       = 32;
    localparam int COST_W      = 30;
    localparam int CCAP_W      = 37;
    localparam int BCAP_W      = 40;
    localparam int CFG_W       = 40;

    localparam logic [EDT_W-1:0] BURST_TOKEN_NS = EDT_W'(1000000000);

    localparam logic [COST_W-1:0] CLASS_COST_RST  = COST_W'(1000000000);
    localparam logic [CCAP_W-1:0] CLASS_CAP_RST   = CCAP_W'(2000000000);
    localparam logic [BCAP_W-1:0] BURST_CAP_RST   = BCAP_W'(1000000000);
    localparam logic [COST_W-1:0] GLOBAL_COST_RST = COST_W'(1000000000);

    typedef enum logic [1:0] {
        CFG_CLASS_COST  = 2'd0,
        CFG_CLASS_CAP   = 2'd1,
        CFG_BURST_CAP   = 2'd2,
        CFG_GLOBAL_COST = 2'd3
    } t_cfg_addr;
endpackage
`default_nettype wire

// ----- hdl/tbb_bucket.sv -----
// One bucket decision: refill when the departure time is past, charge when the cost fits.
`default_nettype none
module tbb_bucket
    import tbb_pkg::*;
(
    input  logic [EDT_W-1:0] i_edt,
    input  logic [EDT_W-1:0] i_cost,
    input  logic [EDT_W-1:0] i_cap,
    input  logic [NOW_W-1:0] i_now,
    output logic             o_ok,
    output logic [EDT_W-1:0] o_edt
);
    logic [EDT_W-1:0] w_now;
    logic [EDT_W-1:0] w_backlog;
    logic [EDT_W-1:0] w_need;

    assign w_now     = {1'b0, i_now};
    assign w_backlog = i_edt - w_now;
    assign w_need    = w_backlog + i_cost;

    always_comb begin
        priority if (w_backlog[EDT_W-1]) begin
            o_ok  = 1'b1;
            o_edt = w_now + i_cost;
        end else if (w_need > i_cap) begin
            o_ok  = 1'b0;
            o_edt = i_edt;
        end else begin
            o_ok  = 1'b1;
            o_edt = i_edt + i_cost;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/edt_token_bucket_with_burst_borrow.sv -----
// Top level of the EDT token bucket rate limiter with burst borrowing.
//
// Usage:
//   Input: present i_class_id and i_now_ns with i_start high; a transaction
//   is taken at each rising edge where i_start is high and o_busy is low.
//   o_busy is high only while i_rst_n is low, so a new packet may be offered every cycle.
//   Output: the verdict (o_pass, o_used_burst) and the class counters after
//   this packet appear with o_valid high for exactly one cycle, once the
//   packet has passed the input register and then the result register.
//   The receiver cannot stall; results keep coming.
//   Throughput: one packet per cycle. The input register feeds a single pass
//   of three bucket units (class, burst, global); per-class state is written
//   at the same edge that loads the result register, so back-to-back packets
//   of one class see each other's updates without extra forwarding.
//   Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
//   (class_cost, class_cap, burst_cap, global_cost) at the clock edge.
//   Reset: synchronous active-low i_rst_n clears all departure times and
//   counters, loads the default configuration and drops any packet in flight.
`default_nettype none
module edt_token_bucket_with_burst_borrow
    import tbb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [CID_W-1:0]  i_class_id,
    input  logic [NOW_W-1:0]  i_now_ns,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output logic              o_valid,
    output logic              o_pass,
    output logic              o_used_burst,
    output logic [CNT_W-1:0]  o_burst_lend_count,
    output logic [CNT_W-1:0]  o_burst_global_count
);
    logic [COST_W-1:0] r_class_cost;
    logic [CCAP_W-1:0] r_class_cap;
    logic [BCAP_W-1:0] r_burst_cap;
    logic [COST_W-1:0] r_global_cost;

    logic [EDT_W-1:0]  r_class_dep  [NUM_CLASSES];
    logic [EDT_W-1:0]  r_burst_dep  [NUM_CLASSES];
    logic [CNT_W-1:0]  r_lend_cnt   [NUM_CLASSES];
    logic [CNT_W-1:0]  r_lendg_cnt  [NUM_CLASSES];
    logic [EDT_W-1:0]  r_global_dep;

    logic              r_in_vld;
    logic [CID_W-1:0]  r_cid;
    logic [NOW_W-1:0]  r_now;

    logic              r_out_vld;
    logic              r_pass;
    logic              r_used;
    logic [CNT_W-1:0]  r_lend_out;
    logic [CNT_W-1:0]  r_lendg_out;

    logic              w_in_range;
    logic              w_c_ok;
    logic              w_b_ok;
    logic              w_g_ok;
    logic [EDT_W-1:0]  w_c_edt;
    logic [EDT_W-1:0]  w_b_edt;
    logic [EDT_W-1:0]  w_g_edt;
    logic [EDT_W-1:0]  w_g_cost;

    logic              n_pass;
    logic              n_used;
    logic              n_wr_class;
    logic              n_wr_burst;
    logic              n_wr_global;
    logic              n_inc_lend;
    logic              n_inc_lendg;
    logic [EDT_W-1:0]  n_burst_dep;
    logic [CNT_W-1:0]  n_lend;
    logic [CNT_W-1:0]  n_lendg;

    assign o_busy     = !i_rst_n;
    assign w_in_range = (32'(r_cid) < NUM_CLASSES);
    assign w_g_cost   = EDT_W'(r_global_cost);

    tbb_bucket u_class (
        .i_edt  (r_class_dep[r_cid]),
        .i_cost (EDT_W'(r_class_cost)),
        .i_cap  (EDT_W'(r_class_cap)),
        .i_now  (r_now),
        .o_ok   (w_c_ok),
        .o_edt  (w_c_edt)
    );

    tbb_bucket u_burst (
        .i_edt  (r_burst_dep[r_cid]),
        .i_cost (BURST_TOKEN_NS),
        .i_cap  (EDT_W'(r_burst_cap)),
        .i_now  (r_now),
        .o_ok   (w_b_ok),
        .o_edt  (w_b_edt)
    );

    tbb_bucket u_global (
        .i_edt  (r_global_dep),
        .i_cost (w_g_cost),
        .i_cap  (w_g_cost),
        .i_now  (r_now),
        .o_ok   (w_g_ok),
        .o_edt  (w_g_edt)
    );

    always_comb begin
        n_pass      = 1'b0;
        n_used      = 1'b0;
        n_wr_class  = 1'b0;
        n_wr_burst  = 1'b0;
        n_wr_global = 1'b0;
        n_inc_lend  = 1'b0;
        n_inc_lendg = 1'b0;
        n_burst_dep = w_g_ok ? w_b_edt : (w_b_edt - BURST_TOKEN_NS);
        priority if (!w_in_range) begin
            n_pass = 1'b0;
        end else if (w_c_ok) begin
            n_pass      = 1'b1;
            n_wr_class  = 1'b1;
            n_wr_global = 1'b1;
        end else if (w_b_ok) begin
            n_wr_burst  = 1'b1;
            n_wr_global = 1'b1;
            n_inc_lend  = 1'b1;
            n_inc_lendg = w_g_ok;
            n_pass      = w_g_ok;
            n_used      = w_g_ok;
        end
        n_lend  = r_lend_cnt[r_cid] + CNT_W'(n_inc_lend);
        n_lendg = r_lendg_cnt[r_cid] + CNT_W'(n_inc_lendg);
    end

    always_ff @(posedge i_clk) begin
        r_cid       <= i_class_id;
        r_now       <= i_now_ns;
        r_pass      <= n_pass;
        r_used      <= n_used;
        r_lend_out  <= w_in_range ? n_lend : '0;
        r_lendg_out <= w_in_range ? n_lendg : '0;
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_class_cost  <= CLASS_COST_RST;
            r_class_cap   <= CLASS_CAP_RST;
            r_burst_cap   <= BURST_CAP_RST;
            r_global_cost <= GLOBAL_COST_RST;
            r_global_dep  <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_class_dep[i] <= '0;
                r_burst_dep[i] <= '0;
                r_lend_cnt[i]  <= '0;
                r_lendg_cnt[i] <= '0;
            end
        end else begin
            r_in_vld  <= i_start && !o_busy;
            r_out_vld <= r_in_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_CLASS_COST:  r_class_cost  <= i_cfg_wdata[COST_W-1:0];
                    CFG_CLASS_CAP:   r_class_cap   <= i_cfg_wdata[CCAP_W-1:0];
                    CFG_BURST_CAP:   r_burst_cap   <= i_cfg_wdata[BCAP_W-1:0];
                    CFG_GLOBAL_COST: r_global_cost <= i_cfg_wdata[COST_W-1:0];
                endcase
            end
            if (r_in_vld) begin
                if (n_wr_class) begin
                    r_class_dep[r_cid] <= w_c_edt;
                end
                if (n_wr_burst) begin
                    r_burst_dep[r_cid] <= n_burst_dep;
                end
                if (n_wr_global) begin
                    r_global_dep <= w_g_edt;
                end
                if (w_in_range) begin
                    r_lend_cnt[r_cid]  <= n_lend;
                    r_lendg_cnt[r_cid] <= n_lendg;
                end
            end
        end
    end

    assign o_valid              = r_out_vld;
    assign o_pass               = r_pass;
    assign o_used_burst         = r_used;
    assign o_burst_lend_count   = r_lend_out;
    assign o_burst_global_count = r_lendg_out;
endmodule
`default_nettype wire

// ----- hdl/tbb_checker.sv -----
// Port-level checks for the EDT token bucket rate limiter, bound to the top level.
`default_nettype none
module tbb_checker
    import tbb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_valid,
    input logic              o_pass,
    input logic              o_used_burst,
    input logic [CNT_W-1:0]  o_burst_lend_count,
    input logic [CNT_W-1:0]  o_burst_global_count
);
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk)
        o_valid |-> $past(i_start && !o_busy, 2))
        else $error("result without a matching transaction");

    a_burst_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_used_burst) |-> o_pass)
        else $error("burst loan reported on a dropped packet");

    a_burst_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_used_burst && (o_burst_lend_count == '0)) |->
            (o_burst_global_count == '0))
        else $error("loan counters out of step");
endmodule

bind edt_token_bucket_with_burst_borrow tbb_checker u_tbb_checker (.*);
`default_nettype wire
